FILE: design/thruster_mix_normalize_macros.svh
// Assertion macros shared by the thruster mixer RTL.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef THRUSTER_MIX_NORMALIZE_MACROS_SVH
`define THRUSTER_MIX_NORMALIZE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TMN_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TMN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tmn_pkg.sv
// Shared constants, types and the mixing function for the thruster mixer.
// No dependencies; all other files but the macro header import it.
package tmn_pkg;

  // Fixed point format: ONE means 1.0.
  localparam int FRAC_BITS = 14;

  localparam int NUM_DEM = 6;
  localparam int NUM_THR = 8;
  localparam int DEM_W   = 16;
  localparam int OUT_W   = 16;

  // A sum has three non-zero terms, so two extra bits cover it.
  localparam int SUM_W = DEM_W + 2;
  localparam int MAG_W = DEM_W + 1;
  localparam int MAX_W = (FRAC_BITS + 1 > MAG_W) ? FRAC_BITS + 1 : MAG_W;

  // Divider: quotient bits resolved per pipeline stage.
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = (FRAC_BITS + DIV_STEPS) / DIV_STEPS;
  localparam int DIV_T      = DIV_STAGES * DIV_STEPS;
  localparam int NUM_W      = MAX_W + FRAC_BITS;
  localparam int RES_W      = (DIV_T + 1 > OUT_W) ? DIV_T + 1 : OUT_W;

  localparam int IN_TDATA_W  = NUM_DEM * DEM_W;
  localparam int OUT_TDATA_W = NUM_THR * OUT_W;

  localparam logic [MAX_W-1:0] ONE = {{(MAX_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  // Mixing matrix, one row per thruster, columns roll..sway.
  localparam int MIX_TBL [NUM_THR][NUM_DEM] = '{
    '{ 0,  0,  1,  0, -1,  1},
    '{ 0,  0, -1,  0, -1, -1},
    '{ 0,  0, -1,  0,  1,  1},
    '{ 0,  0,  1,  0,  1, -1},
    '{ 1, -1,  0, -1,  0,  0},
    '{-1, -1,  0, -1,  0,  0},
    '{ 1,  1,  0, -1,  0,  0},
    '{-1,  1,  0, -1,  0,  0}
  };

  typedef logic signed [DEM_W-1:0] demand_t;
  typedef demand_t [NUM_DEM-1:0] demands_t;

  // One divider lane: partial remainder, dividend bits still to shift in,
  // quotient so far and the sign to apply at the end.
  typedef struct packed {
    logic             neg;
    logic [MAX_W-1:0] rem;
    logic [DIV_T-1:0] num;
    logic [DIV_T-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [NUM_THR-1:0] lane;
    logic [MAX_W-1:0]        divisor;
  } div_item_t;

  // Signed sum of one matrix row against the demands.
  function automatic logic signed [SUM_W-1:0] mix_sum(input int row, input demands_t dem);
    logic signed [SUM_W-1:0] acc;
    acc = '0;
    for (int c = 0; c < NUM_DEM; c++) begin
      case (MIX_TBL[row][c])
        1:       acc = acc + SUM_W'($signed(dem[c]));
        -1:      acc = acc - SUM_W'($signed(dem[c]));
        default: acc = acc;
      endcase
    end
    return acc;
  endfunction

endpackage

FILE: design/tmn_mix.sv
// Front end of the mixer: matrix sums, magnitudes and the frame maximum.
// Depends on tmn_pkg and the assertion macro header.
`include "thruster_mix_normalize_macros.svh"

module tmn_mix (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tmn_pkg::demands_t   dem_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tmn_pkg::div_item_t  item_o
);
  import tmn_pkg::*;

  logic                    va_q, vb_q, vc_q;
  logic                    ra, rb, rc;
  logic signed [SUM_W-1:0] sum_d [NUM_THR];
  logic signed [SUM_W-1:0] sum_q [NUM_THR];
  logic                    neg_d [NUM_THR];
  logic                    neg_q [NUM_THR];
  logic [MAG_W-1:0]        mag_d [NUM_THR];
  logic [MAG_W-1:0]        mag_q [NUM_THR];
  logic [MAG_W-1:0]        pmax_d [NUM_THR/2];
  logic [MAG_W-1:0]        pmax_q [NUM_THR/2];
  logic [MAX_W-1:0]        mx;
  logic [NUM_W-1:0]        n_full;
  div_item_t               item_d, item_q;

  // Each stage takes a new item when it is empty or its contents move on.
  assign rc = !vc_q || out_ready_i;
  assign rb = !vb_q || rc;
  assign ra = !va_q || rb;
  assign in_ready_o  = ra;
  assign out_valid_o = vc_q;
  assign item_o      = item_q;

  // Stage A: one signed sum per thruster.
  always_comb begin
    for (int m = 0; m < NUM_THR; m++) begin
      sum_d[m] = mix_sum(m, dem_i);
    end
  end

  // Stage B: magnitudes and the maximum of each pair.
  always_comb begin
    for (int m = 0; m < NUM_THR; m++) begin
      neg_d[m] = sum_q[m][SUM_W-1];
      mag_d[m] = neg_d[m] ? MAG_W'(-sum_q[m]) : MAG_W'(sum_q[m]);
    end
    for (int p = 0; p < NUM_THR / 2; p++) begin
      pmax_d[p] = (mag_d[2*p] > mag_d[2*p+1]) ? mag_d[2*p] : mag_d[2*p+1];
    end
  end

  // Stage C: frame maximum, floored at ONE, and the divider's start values.
  always_comb begin
    mx = ONE;
    for (int p = 0; p < NUM_THR / 2; p++) begin
      if (MAX_W'(pmax_q[p]) > mx) begin
        mx = MAX_W'(pmax_q[p]);
      end
    end
    item_d.divisor = mx;
    n_full = '0;
    for (int m = 0; m < NUM_THR; m++) begin
      n_full = NUM_W'(mag_q[m]) << FRAC_BITS;
      item_d.lane[m].neg = neg_q[m];
      item_d.lane[m].rem = MAX_W'(n_full >> DIV_T);
      item_d.lane[m].num = n_full[DIV_T-1:0];
      item_d.lane[m].quo = '0;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (ra) va_q <= in_valid_i;
      if (rb) vb_q <= va_q;
      if (rc) vc_q <= vb_q;
    end
  end

  // Payload registers, loaded only with a valid item.
  always_ff @(posedge clk_i) begin
    if (ra && in_valid_i) begin
      sum_q <= sum_d;
    end
    if (rb && va_q) begin
      neg_q  <= neg_d;
      mag_q  <= mag_d;
      pmax_q <= pmax_d;
    end
    if (rc && vb_q) begin
      item_q <= item_d;
    end
  end

  `TMN_ASSERT_NEXT(a_mix_take, in_valid_i && in_ready_o, va_q, "accepted item lost at stage A")
  `TMN_ASSERT(a_div_floor, vc_q, item_q.divisor >= ONE, "frame maximum below ONE")

endmodule

FILE: design/tmn_div_stage.sv
// One divider stage: resolves DIV_STEPS quotient bits on every lane.
// Depends on tmn_pkg and the assertion macro header.
`include "thruster_mix_normalize_macros.svh"

module tmn_div_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tmn_pkg::div_item_t  item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tmn_pkg::div_item_t  item_o
);
  import tmn_pkg::*;

  logic             valid_q;
  logic             ready;
  div_item_t        item_d, item_q;
  logic [MAX_W:0]   trial;
  logic             qbit;
  logic             rem_ok;

  assign ready       = !valid_q || out_ready_i;
  assign in_ready_o  = ready;
  assign out_valid_o = valid_q;
  assign item_o      = item_q;

  // Restoring division: shift in a dividend bit, subtract when it fits.
  always_comb begin
    item_d = item_i;
    trial  = '0;
    qbit   = 1'b0;
    for (int m = 0; m < NUM_THR; m++) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        trial = {item_d.lane[m].rem, item_d.lane[m].num[DIV_T-1]};
        qbit  = trial >= {1'b0, item_d.divisor};
        if (qbit) begin
          trial = trial - {1'b0, item_d.divisor};
        end
        item_d.lane[m].rem = trial[MAX_W-1:0];
        item_d.lane[m].num = item_d.lane[m].num << 1;
        item_d.lane[m].quo = {item_d.lane[m].quo[DIV_T-2:0], qbit};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      item_q <= item_d;
    end
  end

  // Every partial remainder stays below the divisor.
  always_comb begin
    rem_ok = 1'b1;
    for (int m = 0; m < NUM_THR; m++) begin
      if (item_q.lane[m].rem >= item_q.divisor) begin
        rem_ok = 1'b0;
      end
    end
  end

  `TMN_ASSERT(a_rem_below_div, valid_q, rem_ok, "partial remainder not below divisor")

endmodule

FILE: design/thruster_mix_normalize.sv
// Eight-thruster mixer, uniform desaturation by the largest sum magnitude.
// From item accepted to result valid: 3 mixing stages, 5 divider stages
// of 3 quotient bits per lane, 1 output register; the divider lanes are
// fully pipelined. Throughput: one item per cycle unless m_axis_tready
// stalls the output. Reset clears only the valid bits, not the payload.
// Depends on tmn_pkg, tmn_mix, tmn_div_stage and the assertion macro header.
`include "thruster_mix_normalize_macros.svh"

module thruster_mix_normalize (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // roll, pitch, yaw, heave, surge, sway demands, 16 bits each, from bit 0
  input  logic [tmn_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // thruster_1_out .. thruster_8_out, 16 bits each, from bit 0
  output logic [tmn_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import tmn_pkg::*;

  demands_t                 dem;
  logic                     v_chain [DIV_STAGES+1];
  logic                     r_chain [DIV_STAGES+1];
  div_item_t                d_chain [DIV_STAGES+1];
  logic                     out_v_q;
  logic                     r_last;
  logic [OUT_TDATA_W-1:0]   out_data_d, out_data_q;
  logic [RES_W-1:0]         qx;
  logic                     q_ok;

  // Unpack the input item.
  always_comb begin
    for (int c = 0; c < NUM_DEM; c++) begin
      dem[c] = s_axis_tdata[c*DEM_W +: DEM_W];
    end
  end

  tmn_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .dem_i       (dem),
    .out_valid_o (v_chain[0]),
    .out_ready_i (r_chain[0]),
    .item_o      (d_chain[0])
  );

  // Divider pipeline.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    tmn_div_stage u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (v_chain[g]),
      .in_ready_o  (r_chain[g]),
      .item_i      (d_chain[g]),
      .out_valid_o (v_chain[g+1]),
      .out_ready_i (r_chain[g+1]),
      .item_o      (d_chain[g+1])
    );
  end

  assign r_last                = !out_v_q || m_axis_tready;
  assign r_chain[DIV_STAGES]   = r_last;
  assign m_axis_tvalid         = out_v_q;
  assign m_axis_tdata          = out_data_q;

  // Apply the sign and keep the low bits of each result.
  always_comb begin
    qx   = '0;
    q_ok = 1'b1;
    for (int m = 0; m < NUM_THR; m++) begin
      qx = RES_W'(d_chain[DIV_STAGES].lane[m].quo);
      if (d_chain[DIV_STAGES].lane[m].neg) begin
        qx = -qx;
      end
      out_data_d[m*OUT_W +: OUT_W] = qx[OUT_W-1:0];
      if (d_chain[DIV_STAGES].lane[m].quo > ONE) begin
        q_ok = 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (r_last) begin
      out_v_q <= v_chain[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_last && v_chain[DIV_STAGES]) begin
      out_data_q <= out_data_d;
    end
  end

  `TMN_ASSERT(a_quo_le_one, v_chain[DIV_STAGES], q_ok, "scaled magnitude above ONE")
  `TMN_ASSERT(a_empty_ready, !m_axis_tvalid, s_axis_tready, "empty output yet input stalled")
  `TMN_ASSERT_NEXT(a_out_load, v_chain[DIV_STAGES] && r_last, m_axis_tvalid, "result lost")

endmodule

FILE: bench/tb_thruster_mix_normalize.sv
// Self-checking testbench for thruster_mix_normalize: stream driver, stream monitor and an
// independent predictor of the mixing and desaturation; depends on tmn_pkg and the block.
// Directed corner frames come first, then two random batches with stalls on both sides.
module tb_thruster_mix_normalize;

  import tmn_pkg::*;

  // Sign of each demand's contribution to each thruster, columns roll, pitch, yaw,
  // heave, surge, sway.
  localparam int THRUST_SIGN [8][6] = '{
    '{ 0,  0,  1,  0, -1,  1},
    '{ 0,  0, -1,  0, -1, -1},
    '{ 0,  0, -1,  0,  1,  1},
    '{ 0,  0,  1,  0,  1, -1},
    '{ 1, -1,  0, -1,  0,  0},
    '{-1, -1,  0, -1,  0,  0},
    '{ 1,  1,  0, -1,  0,  0},
    '{-1,  1,  0, -1,  0,  0}
  };
  localparam longint UNITY      = longint'(1) << FRAC_BITS;
  localparam int     UNITY_I    = 1 << FRAC_BITS;
  localparam int     STALL_LEN  = 80;
  localparam int     STALL_AT   = 200;
  localparam int     CALM_FIRST = 320;
  localparam int     CALM_LAST  = 440;
  localparam int     BATCH_LEN  = 300;

  logic                   clk_i  = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  demands_t               frame_q [$];
  logic [OUT_TDATA_W-1:0] cmd_q [$];
  logic [OUT_TDATA_W-1:0] cmd_want;
  logic                   frame_taken = 1'b0;
  int                     frames_in   = 0;
  int                     err_cnt     = 0;
  int                     stall_left  = 0;
  logic                   stall_done  = 1'b0;

  thruster_mix_normalize u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mix six demands into eight thruster commands, scaling all of them down together
  // when the largest magnitude exceeds unity.
  function automatic logic [OUT_TDATA_W-1:0] mix_and_desaturate(input demands_t dem);
    longint sums [8];
    longint peak;
    longint mag;
    longint quo;
    logic [OUT_TDATA_W-1:0] cmds;
    peak = UNITY;
    for (int t = 0; t < 8; t++) begin
      sums[t] = 0;
      for (int c = 0; c < 6; c++)
        sums[t] += longint'(THRUST_SIGN[t][c]) * longint'(dem[c]);
      mag = (sums[t] < 0) ? -sums[t] : sums[t];
      if (mag > peak)
        peak = mag;
    end
    for (int t = 0; t < 8; t++) begin
      if (peak > UNITY) begin
        mag = (sums[t] < 0) ? -sums[t] : sums[t];
        quo = (mag * UNITY) / peak;
        sums[t] = (sums[t] < 0) ? -quo : quo;
      end
      cmds[t*OUT_W +: OUT_W] = sums[t][OUT_W-1:0];
    end
    return cmds;
  endfunction

  function automatic demands_t pack_demands(input int roll, input int pitch, input int yaw,
                                            input int heave, input int surge, input int sway);
    demands_t dem;
    dem[0] = roll[DEM_W-1:0];
    dem[1] = pitch[DEM_W-1:0];
    dem[2] = yaw[DEM_W-1:0];
    dem[3] = heave[DEM_W-1:0];
    dem[4] = surge[DEM_W-1:0];
    dem[5] = sway[DEM_W-1:0];
    return dem;
  endfunction

  // One random demand: mostly within unity, some anywhere in 16 bits, some small
  // enough that no scaling happens, and some sitting right at the unity boundary.
  function automatic logic [DEM_W-1:0] random_demand(input int flavour);
    int v;
    case (flavour)
      0, 1, 2, 3, 4, 5: v = int'($urandom_range(2 * UNITY_I)) - UNITY_I;
      6, 7:             v = int'($urandom_range(65535));
      8:                v = int'($urandom_range(UNITY_I / 2)) - UNITY_I / 4;
      default: begin
        v = UNITY_I - 2 + int'($urandom_range(4));
        if ($urandom_range(1) == 1)
          v = -v;
        if ($urandom_range(2) == 0)
          v = 0;
      end
    endcase
    return v[DEM_W-1:0];
  endfunction

  function automatic logic calm_stretch(input int n);
    return (n >= CALM_FIRST) && (n < CALM_LAST);
  endfunction

  // Check results first, then record the item just accepted, so a stray result can
  // never pair with an expectation from the same edge.
  always @(posedge clk_i) begin
    frame_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cmd_q.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, m_axis_tdata);
        err_cnt++;
      end else begin
        cmd_want = cmd_q.pop_front();
        for (int t = 0; t < 8; t++) begin
          if (m_axis_tdata[t*OUT_W +: OUT_W] !== cmd_want[t*OUT_W +: OUT_W]) begin
            $display("%0t: thruster %0d expected %0d got %0d", $time, t + 1,
                     $signed(cmd_want[t*OUT_W +: OUT_W]),
                     $signed(m_axis_tdata[t*OUT_W +: OUT_W]));
            err_cnt++;
          end
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      cmd_q.push_back(mix_and_desaturate(demands_t'(s_axis_tdata)));
      frames_in <= frames_in + 1;
    end
  end

  // Sender: once the current item is taken, offers the next pending one, with random gaps outside the calm stretch.
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || frame_taken) begin
      if (frame_q.size() != 0 && (calm_stretch(frames_in) || $urandom_range(99) >= 16)) begin
        s_axis_tdata  <= frame_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold that fills the pipeline.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!stall_done && frames_in >= STALL_AT) begin
      m_axis_tready <= 1'b0;
      stall_left    <= STALL_LEN;
      stall_done    <= 1'b1;
    end else begin
      m_axis_tready <= calm_stretch(frames_in) || ($urandom_range(99) >= 16);
    end
  end

  // Checked at the rising edge, where the sender's signals and queue are settled.
  task automatic wait_until_drained();
    while (frame_q.size() != 0 || s_axis_tvalid || cmd_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic queue_random_batch(input int count);
    demands_t dem;
    int flavour;
    for (int i = 0; i < count; i++) begin
      flavour = int'($urandom_range(9));
      for (int c = 0; c < 6; c++)
        dem[c] = random_demand(flavour);
      frame_q.push_back(dem);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed frames: zero, each demand alone at plus and minus unity, the 16-bit
    // extremes, a peak of exactly unity and one just above it.
    frame_q.push_back(pack_demands(0, 0, 0, 0, 0, 0));
    for (int c = 0; c < 6; c++) begin
      frame_q.push_back(pack_demands(c == 0 ? UNITY_I : 0, c == 1 ? UNITY_I : 0,
                                     c == 2 ? UNITY_I : 0, c == 3 ? UNITY_I : 0,
                                     c == 4 ? UNITY_I : 0, c == 5 ? UNITY_I : 0));
      frame_q.push_back(pack_demands(c == 0 ? -UNITY_I : 0, c == 1 ? -UNITY_I : 0,
                                     c == 2 ? -UNITY_I : 0, c == 3 ? -UNITY_I : 0,
                                     c == 4 ? -UNITY_I : 0, c == 5 ? -UNITY_I : 0));
    end
    frame_q.push_back(pack_demands(UNITY_I, UNITY_I, UNITY_I, UNITY_I, UNITY_I, UNITY_I));
    frame_q.push_back(pack_demands(-UNITY_I, -UNITY_I, -UNITY_I, -UNITY_I, -UNITY_I,
                                   -UNITY_I));
    frame_q.push_back(pack_demands(32767, 32767, 32767, 32767, 32767, 32767));
    frame_q.push_back(pack_demands(-32768, -32768, -32768, -32768, -32768, -32768));
    frame_q.push_back(pack_demands(32767, -32768, 32767, -32768, -32768, 32767));
    frame_q.push_back(pack_demands(0, 0, UNITY_I / 2, 0, 0, UNITY_I / 2));
    frame_q.push_back(pack_demands(0, 0, UNITY_I / 2 + 1, 0, 0, UNITY_I / 2));
    frame_q.push_back(pack_demands(1, -1, 1, -1, 1, -1));

    // The sender pauses between phases until every result has come back.
    wait_until_drained();
    queue_random_batch(BATCH_LEN);
    wait_until_drained();
    queue_random_batch(BATCH_LEN);
    wait_until_drained();
    repeat (20) @(posedge clk_i);

    // Any expectation left over means a result never came.
    if (cmd_q.size() != 0) begin
      $display("%0t: %0d results expected, 0 received", $time, cmd_q.size());
      err_cnt++;
    end

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/tmn_pkg.sv
design/tmn_mix.sv
design/tmn_div_stage.sv
design/thruster_mix_normalize.sv
bench/tb_thruster_mix_normalize.sv
